// File: hdl/med1d_pkg.sv
`default_nettype none

package med1d_pkg;

  // width of the half_width register word
  localparam int CFG_BITS = 3;

  // reset value of half_width
  localparam logic [CFG_BITS-1:0] HALF_RESET = 3'd1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PLAN  = 6'b000010,
    S_CAND  = 6'b000100,
    S_LOADC = 6'b001000,
    S_SCAN  = 6'b010000,
    S_OUT   = 6'b100000
  } med_state_e;

endpackage

`default_nettype wire

// File: hdl/med1d_sample_if.sv
`default_nettype none

interface med1d_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

// File: hdl/med1d_result_if.sv
`default_nettype none

interface med1d_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median_value;
  logic                          is_final;
  logic                          too_short;

  modport source (output valid, output median_value, output is_final, output too_short,
                  input ready);
  modport sink   (input valid, input median_value, input is_final, input too_short,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/med1d_cfg_if.sv
`default_nettype none

interface med1d_cfg_if;
  import med1d_pkg::*;

  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] half_width;

  modport source (output valid, output half_width, input ready);
  modport sink   (input valid, input half_width, output ready);
endinterface

`default_nettype wire

// File: hdl/median_filter_1d_shrinking_edges.sv
// 1-D median filter with symmetrically shrinking windows at both sequence ends.
//
// Channels: in_i carries one sample word (sample, last_sample); out_o carries
// result words (median_value, is_final, too_short); cfg_i writes half_width,
// always ready, to be written only while the block is idle.
// Samples live in a ring RAM of 2*MAX_HALF+1 words. Each median is found by
// one signed comparator that ranks candidates against the window, one RAM
// word per cycle; at most m candidates are tried for a median over m
// samples, and the result is then held in the output register.
// One sample is processed at a time: in_i is ready only in idle. A sample
// that releases no result leaves the block in idle; otherwise the block returns to
// idle after its last released result is taken.
// A sequence shorter than the window yields one too_short word at its end.
// Results wait in the output register while out_o.ready is low; the sequencer
// holds meanwhile. Reset sets half_width to 1 and starts a new sequence.
`default_nettype none

module median_filter_1d_shrinking_edges #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_HALF    = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  med1d_sample_if.sink    in_i,
  med1d_result_if.source  out_o,
  med1d_cfg_if.sink       cfg_i
);
  import med1d_pkg::*;

  localparam int WIN      = 2 * MAX_HALF + 1;
  localparam int SEEN_SAT = 2 * MAX_HALF + 2;
  localparam int AW       = $clog2(WIN);          // ages, ring addresses
  localparam int NW       = $clog2(SEEN_SAT + 1); // sample count
  localparam int CW       = $clog2(WIN + 1);      // rank counts
  localparam int HW       = $clog2(MAX_HALF + 1);

  med_state_e state_q, state_d;
  logic [CFG_BITS-1:0] half_q, half_d;
  logic [NW-1:0]       seen_q, seen_d;
  logic [AW-1:0]       newest_q, newest_d;

  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] age_q, age_d, end_q, end_d;
  logic          last_q, last_d;
  logic [AW-1:0] r_q, r_d, lo_q, lo_d;
  logic [CW-1:0] m_q, m_d, i_q, i_d, ri_q, ri_d, less_q, less_d, leq_q, leq_d;
  logic signed [SAMPLE_BITS-1:0] cand_q, cand_d;
  logic signed [SAMPLE_BITS-1:0] res_val_q, res_val_d;
  logic          res_fin_q, res_fin_d, res_short_q, res_short_d, done_q, done_d;

  logic [HW-1:0] h;
  logic [NW-1:0] win_n, seen_n, tail, rmin;
  logic [AW-1:0] newest_n, rd_age, raddr;
  logic [CW-1:0] rd_idx, less_n, leq_n;
  logic [AW:0]   addr_w;
  logic          in_acc, out_acc, lt, eq, found;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = (state_q == S_OUT);
  assign out_o.median_value  = res_val_q;
  assign out_o.is_final      = res_fin_q;
  assign out_o.too_short     = res_short_q;

  always_comb begin
    if (32'(half_q) > MAX_HALF) begin
      h = HW'(MAX_HALF);
    end else begin
      h = HW'(half_q);
    end
  end

  assign win_n    = NW'({h, 1'b1});
  assign seen_n   = (seen_q < NW'(SEEN_SAT)) ? seen_q + NW'(1) : NW'(SEEN_SAT);
  assign newest_n = (newest_q == AW'(WIN - 1)) ? '0 : newest_q + AW'(1);

  // ring read address for the sample rd_age steps older than the newest
  always_comb begin
    case (state_q)
      S_LOADC: rd_idx = '0;
      S_SCAN:  rd_idx = ri_q;
      default: rd_idx = i_q;
    endcase
    rd_age = AW'((CW + 1)'(lo_q) + (CW + 1)'(rd_idx));
    if (newest_q >= rd_age) begin
      addr_w = (AW + 1)'(newest_q) - (AW + 1)'(rd_age);
    end else begin
      addr_w = (AW + 1)'(newest_q) + (AW + 1)'(WIN) - (AW + 1)'(rd_age);
    end
    raddr = addr_w[AW-1:0];
  end

  med1d_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WIN)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(newest_n),
    .wdata_i(in_i.sample),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  // the shared comparator
  assign lt     = rd_data < cand_q;
  assign eq     = rd_data == cand_q;
  assign less_n = less_q + CW'(lt);
  assign leq_n  = leq_q + CW'(lt || eq);
  assign found  = (less_n <= CW'(r_q)) && (CW'(r_q) < leq_n);

  // window radius for the position at age_q
  always_comb begin
    tail = n_q - NW'(1) - NW'(age_q);
    rmin = NW'(h);
    if (NW'(age_q) < rmin) begin
      rmin = NW'(age_q);
    end
    if (tail < rmin) begin
      rmin = tail;
    end
  end

  always_comb begin
    state_d     = state_q;
    half_d      = half_q;
    seen_d      = seen_q;
    newest_d    = newest_q;
    n_d         = n_q;
    age_d       = age_q;
    end_d       = end_q;
    last_d      = last_q;
    r_d         = r_q;
    lo_d        = lo_q;
    m_d         = m_q;
    i_d         = i_q;
    ri_d        = ri_q;
    less_d      = less_q;
    leq_d       = leq_q;
    cand_d      = cand_q;
    res_val_d   = res_val_q;
    res_fin_d   = res_fin_q;
    res_short_d = res_short_q;
    done_d      = done_q;

    if (cfg_i.valid) begin
      half_d = cfg_i.half_width;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          newest_d = newest_n;
          n_d      = seen_n;
          seen_d   = in_i.last_sample ? '0 : seen_n;
          last_d   = in_i.last_sample;
          if (seen_n < win_n) begin
            if (in_i.last_sample) begin
              res_val_d   = '0;
              res_fin_d   = 1'b1;
              res_short_d = 1'b1;
              done_d      = 1'b1;
              state_d     = S_OUT;
            end
          end else begin
            // the word that fills the window releases the leading edge too
            age_d   = (seen_n == win_n) ? AW'({h, 1'b0}) : AW'(h);
            end_d   = in_i.last_sample ? '0 : AW'(h);
            state_d = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        r_d     = AW'(rmin);
        lo_d    = age_q - AW'(rmin);
        m_d     = CW'({AW'(rmin), 1'b1});
        i_d     = '0;
        state_d = S_CAND;
      end
      S_CAND: begin
        state_d = S_LOADC;
      end
      S_LOADC: begin
        cand_d  = rd_data;
        ri_d    = CW'(1);
        less_d  = '0;
        leq_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (ri_q < m_q) begin
          ri_d   = ri_q + CW'(1);
          less_d = less_n;
          leq_d  = leq_n;
        end else if (found) begin
          res_val_d   = cand_q;
          res_fin_d   = last_q && (age_q == '0);
          res_short_d = 1'b0;
          done_d      = (age_q == end_q);
          state_d     = S_OUT;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_CAND;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (done_q) begin
            state_d = S_IDLE;
          end else begin
            age_d   = age_q - AW'(1);
            state_d = S_PLAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      half_q   <= HALF_RESET;
      seen_q   <= '0;
      newest_q <= '0;
    end else begin
      state_q  <= state_d;
      half_q   <= half_d;
      seen_q   <= seen_d;
      newest_q <= newest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    age_q       <= age_d;
    end_q       <= end_d;
    last_q      <= last_d;
    r_q         <= r_d;
    lo_q        <= lo_d;
    m_q         <= m_d;
    i_q         <= i_d;
    ri_q        <= ri_d;
    less_q      <= less_d;
    leq_q       <= leq_d;
    cand_q      <= cand_d;
    res_val_q   <= res_val_d;
    res_fin_q   <= res_fin_d;
    res_short_q <= res_short_d;
    done_q      <= done_d;
  end

  a_short_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.too_short |-> out_o.is_final && (out_o.median_value == '0))
    else $error("too_short word carries data or is not final");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (ri_q != '0) && (ri_q <= m_q) && (i_q < m_q))
    else $error("rank scan index out of window");

  a_final_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_o.is_final |=> (state_q == S_IDLE) && (seen_q == '0))
    else $error("final word did not end the sequence");

  a_age_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN) |-> (age_q >= end_q) && (NW'(age_q) < n_q))
    else $error("output position outside the sequence");

endmodule

`default_nettype wire

// File: hdl/med1d_ram.sv
`default_nettype none

module med1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import med1d_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int WIN_DEPTH   = 15;
  localparam int SEEN_SAT    = 16;
  localparam int IDLE_SETTLE = 16;
  localparam int END_SETTLE  = 300;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    is_final;
    logic    undersized;
  } med_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  med1d_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  med1d_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();
  med1d_cfg_if cfg_if ();

  median_filter_1d_shrinking_edges dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  sample_t             hist_q [WIN_DEPTH];
  int unsigned         seen_q;
  logic [CFG_BITS-1:0] width_q;
  med_word_t           med_expected [$];

  int errors;
  int gap_pct;
  int stall_pct;

  task automatic flag_mismatch(input string msg);
    if (errors < 40) $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // median of the samples with ages lo..lo+2r; ties take the element of rank r
  function automatic sample_t rank_median(input int lo, input int r);
    int m;
    int less;
    int leq;
    m = 2 * r + 1;
    for (int i = 0; i < m; i++) begin
      less = 0;
      leq = 0;
      for (int j = 0; j < m; j++) begin
        if (hist_q[lo + j] < hist_q[lo + i]) less++;
        if (hist_q[lo + j] <= hist_q[lo + i]) leq++;
      end
      if (less <= r && r < leq) return hist_q[lo + i];
    end
    return hist_q[lo];
  endfunction

  task automatic push_position(input int n, input int h, input int age, input logic fin);
    med_word_t w;
    int r;
    r = h;
    if (age < r) r = age;
    if (n - 1 - age < r) r = n - 1 - age;
    w.value = rank_median(age - r, r);
    w.is_final = fin;
    w.undersized = 1'b0;
    med_expected.push_back(w);
  endtask

  task automatic predict_medians(input sample_t s, input logic last);
    med_word_t w;
    int h;
    int n;
    h = width_q;
    for (int i = WIN_DEPTH - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = s;
    n = (seen_q < SEEN_SAT) ? seen_q + 1 : SEEN_SAT;
    seen_q = n;
    if (n < 2 * h + 1) begin
      if (last) begin
        w.value = '0;
        w.is_final = 1'b1;
        w.undersized = 1'b1;
        med_expected.push_back(w);
      end
    end else begin
      // window just filled: release the leading positions in one go
      if (n == 2 * h + 1) begin
        for (int a = 2 * h; a >= h; a--) push_position(n, h, a, last && a == 0);
      end else begin
        push_position(n, h, h, last && h == 0);
      end
      if (last) begin
        for (int a = h - 1; a >= 0; a--) push_position(n, h, a, a == 0);
      end
    end
    if (last) seen_q = 0;
  endtask

  task automatic send_sample(input sample_t s, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    in_if.last_sample <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_medians(s, last);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (med_expected.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  // caller makes sure the block is idle
  task automatic write_width(input logic [CFG_BITS-1:0] h);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.half_width <= h;
    do @(posedge clk_i); while (!cfg_if.ready);
    width_q = h;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return sample_t'($urandom);
    if (sel < 65) return sample_t'($urandom_range(6) - 3);  // many ties
    if (sel < 80) return $urandom_range(1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
    return sample_t'($urandom_range(200) - 100);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    med_word_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (med_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected word value=%0d final=%b short=%b",
                                out_if.median_value, out_if.is_final, out_if.too_short));
      end else begin
        w = med_expected.pop_front();
        if (out_if.median_value !== w.value || out_if.is_final !== w.is_final ||
            out_if.too_short !== w.undersized)
          flag_mismatch($sformatf("got value=%0d final=%b short=%b, want %0d/%b/%b",
                                  out_if.median_value, out_if.is_final, out_if.too_short,
                                  w.value, w.is_final, w.undersized));
      end
    end
  end

  // reset width, window exactly full at the last sample, then a lone sample
  task automatic test_default_width();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd5, 1'b1);
    wait_drained();
  endtask

  task automatic test_single_tap();
    write_width(3'd0);
    send_sample(-16'sd1, 1'b1);
    wait_drained();
  endtask

  // widest window, ties and extremes, all positions released by the last sample
  task automatic test_widest_window();
    sample_t vals [15];
    vals = '{16'sh8000, 16'sh7fff, 0, 0, 0, 1, -1, 100, -100, 16'sh7fff, 16'sh8000,
             5, 5, 5, 7};
    write_width(3'd7);
    foreach (vals[i]) send_sample(vals[i], i == 14);
    wait_drained();
  endtask

  task automatic test_width_change_mid_sequence();
    write_width(3'd2);
    send_sample(10, 1'b0);
    send_sample(-20, 1'b0);
    send_sample(30, 1'b0);
    send_sample(-40, 1'b0);
    wait_drained();
    write_width(3'd1);
    send_sample(50, 1'b0);
    send_sample(-60, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int sent;
    int len;
    int h;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      sent = 0;
      while (sent < 52) begin
        if (sent == 0 || $urandom_range(99) < 30) begin
          wait_drained();
          if (phase == 0 && sent == 0) h = 7;
          else if (phase == 1 && sent == 0) h = 0;
          else h = $urandom_range(7);
          write_width(h[CFG_BITS-1:0]);
        end
        h = width_q;
        if (h > 0 && $urandom_range(99) < 15) len = $urandom_range(2 * h, 1);
        else len = $urandom_range(2 * h + 10, 2 * h + 1);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    errors = 0;
    gap_pct = 0;
    stall_pct = 0;
    seen_q = 0;
    width_q = HALF_RESET;
    foreach (hist_q[i]) hist_q[i] = '0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.last_sample = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.half_width = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_width();
    test_single_tap();
    test_widest_window();
    test_width_change_mid_sequence();
    test_random_stream();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (med_expected.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
